// ----- rtl/dzf_pkg.sv -----
// Shared types, constants and the exponential table for the deadzone follower.
// Used by dzf_ctrl, dzf_datapath and deadzone_exponential_follower_core.
`timescale 1ns / 1ps
package dzf_pkg;

   localparam int POS_W      = 32;
   localparam int EXP_DEPTH  = 256;
   localparam int IDX_W      = $clog2(EXP_DEPTH);
   localparam int RATE_W     = 15;
   localparam int RADIUS_W   = 21;
   localparam int DT_W       = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CNT_W      = 5;

   localparam logic [30:0]         Q30_ONE       = 31'h4000_0000;
   localparam logic [RATE_W-1:0]   DEFAULT_RATE  = 15'd1280;
   localparam logic [RADIUS_W-1:0] RESET_RADIUS  = 21'd81920;
   localparam logic [POS_W-1:0]    RESET_MAX     = 32'd4096000;
   localparam logic [CNT_W-1:0]    SQRT_LAST     = 5'd31;
   localparam logic [CNT_W-1:0]    DIV_LAST      = 5'd29;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RATE    = 3'd0,
      REG_RADIUS  = 3'd1,
      REG_CLAMP   = 3'd2,
      REG_MIN_X   = 3'd3,
      REG_MIN_Y   = 3'd4,
      REG_MAX_X   = 3'd5,
      REG_MAX_Y   = 3'd6,
      REG_UNUSED  = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_DIFF, OP_SQX, OP_SQY, OP_SQRT_INIT, OP_SQRT_STEP,
      OP_CHECK, OP_EXP_STEP, OP_MOVE, OP_DIV_INIT, OP_DIV_STEP, OP_STEPX,
      OP_STEPY, OP_UPDATE, OP_OUT
   } dp_op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQRT_INIT, S_SQRT, S_CHECK, S_BRANCH,
      S_EXP, S_MOVE, S_DIV_INIT, S_DIV, S_STEPX, S_STEPY, S_UPDATE, S_OUT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic exp_done;
      logic held;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic [RATE_W-1:0]       rate;
      logic [RADIUS_W-1:0]     radius;
      logic                    clamp;
      logic signed [POS_W-1:0] min_x;
      logic signed [POS_W-1:0] min_y;
      logic signed [POS_W-1:0] max_x;
      logic signed [POS_W-1:0] max_y;
   } cfg_type;

   typedef logic [30:0] exp_table_type [EXP_DEPTH];

   // Shift-and-subtract quotient, only evaluated while the table and E_ONE are built.
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r    = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-num/EXP_DEPTH) in Q1.30 from the alternating power series.
   function automatic logic [30:0] exp_entry(input int unsigned num);
      longint          sum;
      longint unsigned term;
      bit              done;
      sum  = longint'(Q30_ONE);
      term = longint'(Q30_ONE);
      done = 1'b0;
      for (int k = 1; k <= 24; k++) begin
         if (!done) begin
            term = udiv64(term * num, longint'(EXP_DEPTH) * k);
            if (term == 0) done = 1'b1;
            else if (k[0]) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
      return 31'(sum);
   endfunction

   function automatic exp_table_type build_exp_table();
      exp_table_type t;
      for (int i = 0; i < EXP_DEPTH; i++) t[i] = exp_entry(i);
      return t;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();
   localparam logic [30:0]   E_ONE     = exp_entry(EXP_DEPTH);

endpackage

// ----- rtl/deadzone_exponential_follower_core.sv -----
// Top level of the deadzone follower: configuration registers, sequencer and
// datapath. Depends on dzf_pkg, dzf_ctrl and dzf_datapath.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_tvalid/tready    goal_x, goal_y, elapsed
//   rsp      out        rsp_tvalid/tready    view_x, view_y; tuser held
//   csr      in         csr_valid/ready      csr_index, csr_data
//
// Inside the deadzone an item skips the exponent, move, divider and update
// phases. Otherwise the exponent multiply loop runs once per unit of n, where n is
// the integer part of rate * elapsed (0..127), and ends early once the decay
// reaches zero.
// One item is processed at a time; the finished result waits in an output
// register while the next item is taken, and a result still waiting there holds
// the sequencer until it is taken. Reset is synchronous and restores the
// default configuration and a zero position.
`timescale 1ns / 1ps
module deadzone_exponential_follower_core
   import dzf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [79:0]          req_tdata,   // goal_x[31:0], goal_y[63:32], elapsed[79:64]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,   // view_x[31:0], view_y[63:32]
   output logic                 rsp_tuser,   // held
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [POS_W-1:0]     csr_data
);

   cfg_type       cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate   <= DEFAULT_RATE;
         cfg_ff.radius <= RESET_RADIUS;
         cfg_ff.clamp  <= 1'b0;
         cfg_ff.min_x  <= '0;
         cfg_ff.min_y  <= '0;
         cfg_ff.max_x  <= RESET_MAX;
         cfg_ff.max_y  <= RESET_MAX;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_RATE: begin
               // A zero rate falls back to the default speed.
               cfg_ff.rate <= (csr_data[RATE_W-1:0] == '0) ? DEFAULT_RATE
                                                           : csr_data[RATE_W-1:0];
            end
            REG_RADIUS: cfg_ff.radius <= csr_data[RADIUS_W-1:0];
            REG_CLAMP:  cfg_ff.clamp  <= csr_data[0];
            REG_MIN_X:  cfg_ff.min_x  <= csr_data;
            REG_MIN_Y:  cfg_ff.min_y  <= csr_data;
            REG_MAX_X:  cfg_ff.max_x  <= csr_data;
            REG_MAX_Y:  cfg_ff.max_y  <= csr_data;
            default: ;
         endcase
      end
   end

   dzf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dzf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg_ff),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/dzf_ctrl.sv -----
// Sequencer for the follower: walks the datapath through distance, exponent,
// direction and update phases. Depends on dzf_pkg.
`timescale 1ns / 1ps
module dzf_ctrl
   import dzf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd.op   = OP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = OP_SQY;
            state_in = S_SQRT_INIT;
         end
         S_SQRT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            cnt_in   = SQRT_LAST;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            if (cnt_ff == '0) state_in = S_CHECK;
            else cnt_in = cnt_ff - 1'b1;
         end
         S_CHECK: begin
            cmd.op   = OP_CHECK;
            state_in = S_BRANCH;
         end
         S_BRANCH: begin
            state_in = status.held ? S_OUT : S_EXP;
         end
         S_EXP: begin
            if (status.exp_done) state_in = S_MOVE;
            else cmd.op = OP_EXP_STEP;
         end
         S_MOVE: begin
            cmd.op   = OP_MOVE;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = DIV_LAST;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == '0) state_in = S_STEPX;
            else cnt_in = cnt_ff - 1'b1;
         end
         S_STEPX: begin
            cmd.op   = OP_STEPX;
            state_in = S_STEPY;
         end
         S_STEPY: begin
            cmd.op   = OP_STEPY;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.op   = OP_UPDATE;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   property p_sqrt_count;
      @(posedge clock) disable iff (reset)
         (state_ff == S_SQRT_INIT) |=> (state_ff == S_SQRT && cnt_ff == SQRT_LAST);
   endproperty
   a_sqrt_count: assert property (p_sqrt_count) else $error("sqrt count not loaded");

   property p_out_blocked;
      @(posedge clock) disable iff (reset)
         (state_ff == S_OUT && !status.out_free) |=> (state_ff == S_OUT);
   endproperty
   a_out_blocked: assert property (p_out_blocked) else $error("result slot overrun");

   property p_exp_leave;
      @(posedge clock) disable iff (reset)
         (state_ff == S_EXP && status.exp_done) |=> (state_ff == S_MOVE);
   endproperty
   a_exp_leave: assert property (p_exp_leave) else $error("exponent loop did not exit");

endmodule

// ----- rtl/dzf_datapath.sv -----
// Datapath of the follower: distance by digit-recurrence square root, the
// exponent by table and repeated multiply, two dividers, update and clamp.
// Depends on dzf_pkg.
`timescale 1ns / 1ps
module dzf_datapath
   import dzf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  cfg_type               cfg,
   input  logic [79:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,
   output logic                  rsp_tuser
);

   logic signed [POS_W-1:0] goal_x_ff, goal_y_ff, smooth_x_ff, smooth_y_ff;
   logic [DT_W-1:0]         dt_ff;
   logic                    neg_x_ff, neg_y_ff, sh_ff, held_ff;
   logic [30:0]             mx_ff, my_ff, e_ff, qx_ff, qy_ff;
   logic [63:0]             prod_ff, radicand_ff;
   logic [61:0]             sq_ff;
   logic [32:0]             rem_ff, excess_ff, move_ff, step_x_ff;
   logic [31:0]             root_ff, div_rx_ff, div_ry_ff;
   logic [6:0]              n_ff;
   logic                    rsp_valid_ff, rsp_held_ff;
   logic [POS_W-1:0]        rsp_x_ff, rsp_y_ff;

   // Shared multiplier: 33 by 31 bits as a 32 by 31 product plus one term.
   logic [32:0] mul_a;
   logic [30:0] mul_b;
   logic [62:0] mul_pp;
   logic [63:0] mul_out;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_SQX:      begin mul_a = {2'b00, mx_ff}; mul_b = mx_ff; end
         OP_SQY:      begin mul_a = {2'b00, my_ff}; mul_b = my_ff; end
         OP_EXP_STEP: begin mul_a = {2'b00, e_ff};  mul_b = E_ONE; end
         OP_MOVE:     begin mul_a = excess_ff;      mul_b = Q30_ONE - e_ff; end
         OP_STEPX:    begin mul_a = move_ff;        mul_b = qx_ff; end
         OP_STEPY:    begin mul_a = move_ff;        mul_b = qy_ff; end
         default:     ;
      endcase
      mul_pp  = 63'(mul_a[31:0]) * 63'(mul_b);
      mul_out = {1'b0, mul_pp} + (mul_a[32] ? {1'b0, mul_b, 32'b0} : 64'd0);
   end

   // Difference and magnitudes.
   logic signed [POS_W:0] dx, dy;
   logic [POS_W:0]        ax, ay;
   logic                  sh;
   always_comb begin
      dx = {goal_x_ff[POS_W-1], goal_x_ff} - {smooth_x_ff[POS_W-1], smooth_x_ff};
      dy = {goal_y_ff[POS_W-1], goal_y_ff} - {smooth_y_ff[POS_W-1], smooth_y_ff};
      ax = dx[POS_W] ? 33'(-dx) : 33'(dx);
      ay = dy[POS_W] ? 33'(-dy) : 33'(dy);
      sh = ax[31] | ay[31];
   end

   // One square-root digit a cycle.
   logic [34:0] sq_cat, sq_trial;
   always_comb begin
      sq_cat   = {rem_ff, radicand_ff[63:62]};
      sq_trial = {1'b0, root_ff, 2'b01};
   end

   // Distance, deadzone test, exponent split.
   logic [32:0] distance;
   logic [30:0] expo;
   always_comb begin
      distance = sh_ff ? {root_ff, 1'b0} : {1'b0, root_ff};
      expo     = 31'(cfg.rate) * 31'(dt_ff);
   end

   // Divider first digit and restoring steps.
   logic        qx0, qy0;
   logic [32:0] rx2, ry2;
   always_comb begin
      qx0 = {1'b0, mx_ff} >= root_ff;
      qy0 = {1'b0, my_ff} >= root_ff;
      rx2 = {div_rx_ff, 1'b0};
      ry2 = {div_ry_ff, 1'b0};
   end

   // Position update: signed step, saturation, optional clamp.
   logic signed [34:0] sum_x, sum_y;
   logic signed [POS_W-1:0] sat_x, sat_y, new_x, new_y;
   localparam logic signed [34:0] POS_MAX = 35'sd2147483647;
   localparam logic signed [34:0] POS_MIN = -35'sd2147483648;
   always_comb begin
      sum_x = neg_x_ff ? 35'(smooth_x_ff) - $signed({2'b00, step_x_ff})
                       : 35'(smooth_x_ff) + $signed({2'b00, step_x_ff});
      sum_y = neg_y_ff ? 35'(smooth_y_ff) - $signed({2'b00, prod_ff[62:30]})
                       : 35'(smooth_y_ff) + $signed({2'b00, prod_ff[62:30]});
      if (sum_x > POS_MAX) sat_x = POS_MAX[POS_W-1:0];
      else if (sum_x < POS_MIN) sat_x = POS_MIN[POS_W-1:0];
      else sat_x = sum_x[POS_W-1:0];
      if (sum_y > POS_MAX) sat_y = POS_MAX[POS_W-1:0];
      else if (sum_y < POS_MIN) sat_y = POS_MIN[POS_W-1:0];
      else sat_y = sum_y[POS_W-1:0];
      new_x = sat_x;
      new_y = sat_y;
      if (cfg.clamp) begin
         if (sat_x > cfg.max_x) new_x = cfg.max_x;
         else if (sat_x < cfg.min_x) new_x = cfg.min_x;
         if (sat_y > cfg.max_y) new_y = cfg.max_y;
         else if (sat_y < cfg.min_y) new_y = cfg.min_y;
      end
   end

   // Control-bearing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_x_ff  <= '0;
         smooth_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_UPDATE) begin
            smooth_x_ff <= new_x;
            smooth_y_ff <= new_y;
         end
         if (cmd.op == OP_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            goal_x_ff <= req_tdata[31:0];
            goal_y_ff <= req_tdata[63:32];
            dt_ff     <= req_tdata[79:64];
         end
         OP_DIFF: begin
            neg_x_ff <= dx[POS_W];
            neg_y_ff <= dy[POS_W];
            sh_ff    <= sh;
            mx_ff    <= sh ? ax[31:1] : ax[30:0];
            my_ff    <= sh ? ay[31:1] : ay[30:0];
         end
         OP_SQX: prod_ff <= mul_out;
         OP_SQY: begin
            sq_ff   <= prod_ff[61:0];
            prod_ff <= mul_out;
         end
         OP_SQRT_INIT: begin
            radicand_ff <= {2'b00, sq_ff} + prod_ff;
            rem_ff      <= '0;
            root_ff     <= '0;
         end
         OP_SQRT_STEP: begin
            radicand_ff <= {radicand_ff[61:0], 2'b00};
            if (sq_cat >= sq_trial) begin
               rem_ff  <= 33'(sq_cat - sq_trial);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= sq_cat[32:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         OP_CHECK: begin
            held_ff   <= distance <= 33'(cfg.radius);
            excess_ff <= distance - 33'(cfg.radius);
            n_ff      <= expo[30:24];
            e_ff      <= EXP_TABLE[expo[23 -: IDX_W]];
         end
         OP_EXP_STEP: begin
            e_ff <= mul_out[60:30];
            n_ff <= n_ff - 1'b1;
         end
         OP_MOVE: prod_ff <= mul_out;
         OP_DIV_INIT: begin
            move_ff   <= prod_ff[62:30];
            qx_ff     <= {30'b0, qx0};
            qy_ff     <= {30'b0, qy0};
            div_rx_ff <= qx0 ? 32'({1'b0, mx_ff} - root_ff) : {1'b0, mx_ff};
            div_ry_ff <= qy0 ? 32'({1'b0, my_ff} - root_ff) : {1'b0, my_ff};
         end
         OP_DIV_STEP: begin
            if (rx2 >= {1'b0, root_ff}) begin
               div_rx_ff <= 32'(rx2 - {1'b0, root_ff});
               qx_ff     <= {qx_ff[29:0], 1'b1};
            end else begin
               div_rx_ff <= rx2[31:0];
               qx_ff     <= {qx_ff[29:0], 1'b0};
            end
            if (ry2 >= {1'b0, root_ff}) begin
               div_ry_ff <= 32'(ry2 - {1'b0, root_ff});
               qy_ff     <= {qy_ff[29:0], 1'b1};
            end else begin
               div_ry_ff <= ry2[31:0];
               qy_ff     <= {qy_ff[29:0], 1'b0};
            end
         end
         OP_STEPX: prod_ff <= mul_out;
         OP_STEPY: begin
            step_x_ff <= prod_ff[62:30];
            prod_ff   <= mul_out;
         end
         OP_OUT: begin
            rsp_x_ff    <= smooth_x_ff;
            rsp_y_ff    <= smooth_y_ff;
            rsp_held_ff <= held_ff;
         end
         default: ;
      endcase
   end

   assign status.exp_done = (n_ff == '0) || (e_ff == '0);
   assign status.held     = held_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser       = rsp_held_ff;

   property p_root_nonzero;
      @(posedge clock) disable iff (reset)
         (cmd.op == OP_DIV_INIT) |-> (root_ff != '0);
   endproperty
   a_root_nonzero: assert property (p_root_nonzero) else $error("divide by zero root");

   property p_unit_range;
      @(posedge clock) disable iff (reset)
         (cmd.op == OP_STEPX) |-> (qx_ff <= Q30_ONE && qy_ff <= Q30_ONE);
   endproperty
   a_unit_range: assert property (p_unit_range) else $error("direction above one");

   property p_no_overwrite;
      @(posedge clock) disable iff (reset)
         (cmd.op == OP_OUT) |-> (!rsp_valid_ff || rsp_tready);
   endproperty
   a_no_overwrite: assert property (p_no_overwrite) else $error("pending result lost");

   property p_clamped;
      @(posedge clock) disable iff (reset)
         (cmd.op == OP_UPDATE && cfg.clamp && cfg.min_x <= cfg.max_x) |=>
            (smooth_x_ff >= cfg.min_x && smooth_x_ff <= cfg.max_x);
   endproperty
   a_clamped: assert property (p_clamped) else $error("position outside bounds");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for deadzone_exponential_follower_core: a built-in
// follower predictor in a scoreboard class, stream drivers and a result checker.
// Depends on dzf_pkg and the RTL of the follower core.
`timescale 1ns / 1ps
module testbench;
   import dzf_pkg::*;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int SETTLE_CYCLES = 260;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic        held;
   } view_type;

   class follower_scoreboard;
      bit [14:0] rate;
      bit [20:0] radius;
      bit        clamp;
      longint    min_x, min_y, max_x, max_y;
      longint    pos_x, pos_y;
      view_type  pending[$];
      int        errors;

      function void reset_state();
         rate = DEFAULT_RATE;
         radius = RESET_RADIUS;
         clamp = 1'b0;
         min_x = 0;
         min_y = 0;
         max_x = 4096000;
         max_y = 4096000;
         pos_x = 0;
         pos_y = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [31:0] d);
         case (idx)
            REG_RATE: begin
               rate = d[14:0];
               if (rate == 0) rate = DEFAULT_RATE;
            end
            REG_RADIUS: radius = d[20:0];
            REG_CLAMP: clamp = d[0];
            REG_MIN_X: min_x = longint'(signed'(d));
            REG_MIN_Y: min_y = longint'(signed'(d));
            REG_MAX_X: max_x = longint'(signed'(d));
            REG_MAX_Y: max_y = longint'(signed'(d));
            default: ;
         endcase
      endfunction

      // exp(-num/256) in Q1.30 by the alternating power series.
      function longint unsigned decay(longint unsigned num);
         longint          acc;
         longint unsigned term;
         acc = longint'(Q30_ONE);
         term = Q30_ONE;
         for (int k = 1; k <= 24; k++) begin
            term = term * num / (longint'(EXP_DEPTH) * k);
            if (term == 0) break;
            if (k % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
         end
         if (acc < 0) acc = 0;
         if (acc > longint'(Q30_ONE)) acc = longint'(Q30_ONE);
         return longint'(acc);
      endfunction

      function longint unsigned scale_q30(longint unsigned a, longint unsigned b);
         return (a >> 30) * b + (((a & (longint'(Q30_ONE) - 1)) * b) >> 30);
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function longint saturate(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint bound(longint v, longint lo, longint hi);
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function void note_goal(logic [79:0] d);
         longint          gx, gy, dx, dy, nx, ny;
         longint unsigned ax, ay, mx, my, root, span, a, n, idx, e, e1, move, ux, uy;
         int              sh;
         view_type        v;
         gx = longint'(signed'(d[31:0]));
         gy = longint'(signed'(d[63:32]));
         dx = gx - pos_x;
         dy = gy - pos_y;
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         sh = 0;
         while ((ax >> sh) >= 64'd2147483648 || (ay >> sh) >= 64'd2147483648) sh++;
         mx = ax >> sh;
         my = ay >> sh;
         root = int_sqrt(mx * mx + my * my);
         span = root << sh;
         v.held = span <= radius;
         if (!v.held) begin
            a = longint'(rate) * d[79:64];
            n = a >> 24;
            idx = ((a & 64'hFF_FFFF) * EXP_DEPTH) >> 24;
            e = decay(idx);
            e1 = decay(EXP_DEPTH);
            for (longint unsigned i = 0; i < n && e != 0; i++) e = scale_q30(e, e1);
            move = scale_q30(span - radius, longint'(Q30_ONE) - e);
            ux = (mx << 30) / root;
            uy = (my << 30) / root;
            if (ux > Q30_ONE) ux = Q30_ONE;
            if (uy > Q30_ONE) uy = Q30_ONE;
            ux = scale_q30(move, ux);
            uy = scale_q30(move, uy);
            nx = saturate(dx < 0 ? pos_x - longint'(ux) : pos_x + longint'(ux));
            ny = saturate(dy < 0 ? pos_y - longint'(uy) : pos_y + longint'(uy));
            if (clamp) begin
               nx = bound(nx, min_x, max_x);
               ny = bound(ny, min_y, max_y);
            end
            pos_x = nx;
            pos_y = ny;
         end
         v.x = pos_x[31:0];
         v.y = pos_y[31:0];
         pending.push_back(v);
      endfunction

      function void check_view(logic [63:0] d, logic u);
         view_type v;
         if (pending.size() == 0) begin
            $error("unexpected result transaction: view_x %h view_y %h", d[31:0], d[63:32]);
            errors++;
            return;
         end
         v = pending.pop_front();
         if (d[31:0] !== v.x) begin
            $error("view_x expected %h actual %h", v.x, d[31:0]);
            errors++;
         end
         if (d[63:32] !== v.y) begin
            $error("view_y expected %h actual %h", v.y, d[63:32]);
            errors++;
         end
         if (u !== v.held) begin
            $error("held expected %b actual %b", v.held, u);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [79:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [POS_W-1:0]     csr_data = '0;

   follower_scoreboard sb = new();
   bit  idle_on = 1'b1;
   int  cycles = 0;

   deadzone_exponential_follower_core i_dut (.*);

   always #6 clock = ~clock;

   function automatic int gap_len();
      if (!idle_on) return 0;
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
      return $urandom_range(3, 40);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) sb.check_view(rsp_tdata, rsp_tuser);
      if (cycles > LIMIT_CYCLES) begin
         $display("deadzone_exponential_follower_core: mismatch");
         $finish;
      end
   end

   // Result side: accept runs alternate with random stalls while idle_on is set.
   initial begin
      int g;
      @(negedge clock);
      forever begin
         rsp_tready = 1'b1;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         g = gap_len();
         if (g > 0) begin
            rsp_tready = 1'b0;
            repeat (g) @(negedge clock);
         end
      end
   end

   task automatic write_reg(reg_index_type idx, logic [31:0] d);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = d;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, d);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_goal(longint gx, longint gy, logic [15:0] dt);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {dt, gy[31:0], gx[31:0]};
      do @(posedge clock); while (!req_tready);
      sb.note_goal(req_tdata);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   task automatic random_goals(int count);
      longint ox, oy, r;
      int     k;
      for (int i = 0; i < count; i++) begin
         r = longint'(sb.radius) + 1;
         k = $urandom_range(0, 9);
         if (k < 3) begin
            // Around the deadzone edge, so held and moving frames both occur.
            ox = longint'($urandom_range(0, 2 * r)) - r;
            oy = longint'($urandom_range(0, 2 * r)) - r;
            ox = sb.pos_x + ox;
            oy = sb.pos_y + oy;
         end else if (k < 7) begin
            ox = sb.pos_x + longint'(signed'(20'($urandom())));
            oy = sb.pos_y + longint'(signed'(24'($urandom())));
         end else begin
            ox = longint'(signed'($urandom()));
            oy = longint'(signed'($urandom()));
         end
         if (ox > 64'sd2147483647 || ox < -64'sd2147483648) ox = longint'(signed'($urandom()));
         if (oy > 64'sd2147483647 || oy < -64'sd2147483648) oy = longint'(signed'($urandom()));
         send_goal(ox, oy, $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 4000)));
      end
      drain();
   endtask

   initial begin
      sb.reset_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed frames under the reset configuration.
      send_goal(0, 0, 16'd1000);
      send_goal(81920, 0, 16'd1000);
      send_goal(81921, 0, 16'd1000);
      send_goal(4096000, -4096000, 16'd0);
      send_goal(4096000, -4096000, 16'hFFFF);
      send_goal(64'sd2147483647, 64'sd2147483647, 16'hFFFF);
      send_goal(-64'sd2147483648, -64'sd2147483648, 16'hFFFF);
      send_goal(-64'sd2147483648, 64'sd2147483647, 16'h8000);
      send_goal(64'sd2147483647, -64'sd2147483648, 16'd1);
      send_goal(sb.pos_x, sb.pos_y, 16'd300);
      send_goal(sb.pos_x + 20000, sb.pos_y - 30000, 16'd300);
      drain();
      random_goals(250);

      // Fast follow, no deadzone, tight bounds; the unused index is ignored.
      write_reg(REG_RATE, 32'hFFFF_FFFF);
      write_reg(REG_RADIUS, 32'd0);
      write_reg(REG_CLAMP, 32'hFFFF_FFFF);
      write_reg(REG_MIN_X, -32'sd409600);
      write_reg(REG_MIN_Y, -32'sd409600);
      write_reg(REG_MAX_X, 32'sd409600);
      write_reg(REG_MAX_Y, 32'sd819200);
      write_reg(REG_UNUSED, 32'h0000_0001);
      send_goal(64'sd2147483647, -64'sd2147483648, 16'hFFFF);
      send_goal(0, 0, 16'd0);
      random_goals(250);

      // Rate field written as zero falls back to the default; min above max on x.
      idle_on = 1'b0;
      write_reg(REG_RATE, 32'h0000_8000);
      write_reg(REG_RADIUS, 32'hFFFF_FFFF);
      write_reg(REG_MIN_X, 32'sd1000000);
      write_reg(REG_MAX_X, -32'sd1000000);
      write_reg(REG_MIN_Y, 32'h8000_0000);
      write_reg(REG_MAX_Y, 32'h7FFF_FFFF);
      random_goals(250);
      idle_on = 1'b1;

      // Low rate, wide deadzone, clamping off.
      write_reg(REG_RATE, 32'd26);
      write_reg(REG_RADIUS, 32'd2048000);
      write_reg(REG_CLAMP, 32'd0);
      random_goals(250);

      // Random settings for the rest of the run.
      for (int p = 0; p < 4; p++) begin
         write_reg(REG_RATE, $urandom_range(26, 25600));
         write_reg(REG_RADIUS, $urandom_range(0, 400000));
         write_reg(REG_CLAMP, $urandom());
         write_reg(REG_MIN_X, -$urandom_range(0, 32'h3FFF_FFFF));
         write_reg(REG_MIN_Y, -$urandom_range(0, 32'h3FFF_FFFF));
         write_reg(REG_MAX_X, $urandom_range(0, 32'h3FFF_FFFF));
         write_reg(REG_MAX_Y, $urandom_range(0, 32'h3FFF_FFFF));
         random_goals(100);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("deadzone_exponential_follower_core: match");
      end else begin
         $display("deadzone_exponential_follower_core: mismatch");
      end
      $finish;
   end

endmodule
